/* rtl/abmt_pkg.sv */
package abmt_pkg;

   // Table size used when the top level is not given another depth
   localparam int DEFAULT_TABLE_DEPTH = 64;

   // Field widths
   localparam int FUNC_WIDTH = 2;
   localparam int ADDR_WIDTH = 32;

   // Operation codes carried by req_func
   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   // Table update command: add, remove or clear
   typedef struct packed {
      logic add;
      logic remove;
      logic clear;
   } table_cmd_type;

endpackage

/* rtl/abmt_alloc.sv */
module abmt_alloc
   import abmt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic [TABLE_DEPTH-1:0] valid_vec,
   output logic [TABLE_DEPTH-1:0] add_sel,
   output logic                   full
);

   logic [TABLE_DEPTH-1:0] free_vec;

   // Lowest free slot as a one-hot vector: isolate the lowest set bit
   assign free_vec = ~valid_vec;
   assign add_sel  = free_vec & (~free_vec + TABLE_DEPTH'(1));
   assign full     = ~|free_vec;

endmodule

/* rtl/abmt_array.sv */
module abmt_array
   import abmt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ADDR_WIDTH-1:0]  key,
   input  table_cmd_type          cmd,
   input  logic [TABLE_DEPTH-1:0] add_sel,
   output logic [TABLE_DEPTH-1:0] valid_vec,
   output logic                   hit
);

   logic [ADDR_WIDTH-1:0]  entry_addr_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] entry_valid_ff;
   logic [TABLE_DEPTH-1:0] entry_valid_in;
   logic [TABLE_DEPTH-1:0] match_vec;

   // Per-entry compare, only valid entries take part
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match_vec[i] = entry_valid_ff[i] && (entry_addr_ff[i] == key);
      end
   end

   assign hit       = |match_vec;
   assign valid_vec = entry_valid_ff;

   // Valid bit update; clear keeps the stored addresses
   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (cmd.clear) begin
         entry_valid_in = '0;
      end else if (cmd.remove) begin
         entry_valid_in = entry_valid_ff & ~match_vec;
      end else if (cmd.add) begin
         entry_valid_in = entry_valid_ff | add_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   // Address storage, written only into the selected free slot
   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (cmd.add && add_sel[i]) begin
            entry_addr_ff[i] <= key;
         end
      end
   end

endmodule

/* rtl/address_blacklist_match_table.sv */
// Exact-match blacklist of IPv4 addresses held in a table of TABLE_DEPTH
// entries, each compared in parallel. An item is taken on every cycle that
// start is high (busy is never raised), and its result appears on the rsp_
// ports with rsp_valid for exactly one cycle, from the result register;
// the receiver cannot stall, so results must be captured when they
// come. One item per cycle is sustained: the parallel compare of all entries
// and the lowest-free-slot pick sit between the input and result registers,
// and each item sees the table as left by the item before it. Lookup drops an
// IPv4 packet whose address matches a valid entry; add inserts an absent
// address into the lowest free slot, reporting status 1 when the table is
// full; remove and clear invalidate entries. Reset empties the table.
module address_blacklist_match_table
   import abmt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FUNC_WIDTH-1:0] req_func,
   input  logic [ADDR_WIDTH-1:0] req_addr,
   input  logic                  req_is_ipv4,
   output logic                  rsp_valid,
   output logic                  rsp_drop,
   output logic                  rsp_status
);

   logic                   in_valid_ff;
   func_type               in_func_ff;
   logic [ADDR_WIDTH-1:0]  in_addr_ff;
   logic                   in_is_ipv4_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_drop_ff;
   logic                   rsp_status_ff;
   logic                   rsp_drop_in;
   logic                   rsp_status_in;

   table_cmd_type          cmd;
   logic [TABLE_DEPTH-1:0] valid_vec;
   logic [TABLE_DEPTH-1:0] add_sel;
   logic                   hit;
   logic                   full;

   // Never stalls the sender
   assign busy = 1'b0;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_func_ff    <= func_type'(req_func);
         in_addr_ff    <= req_addr;
         in_is_ipv4_ff <= req_is_ipv4;
      end
   end

   abmt_array #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_array (
      .clock    (clock),
      .reset    (reset),
      .key      (in_addr_ff),
      .cmd      (cmd),
      .add_sel  (add_sel),
      .valid_vec(valid_vec),
      .hit      (hit)
   );

   abmt_alloc #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_alloc (
      .valid_vec(valid_vec),
      .add_sel  (add_sel),
      .full     (full)
   );

   // Operation decode
   always_comb begin
      cmd           = '0;
      rsp_drop_in   = 1'b0;
      rsp_status_in = 1'b0;
      if (in_valid_ff) begin
         case (in_func_ff)
            FUNC_LOOKUP: begin
               rsp_drop_in = in_is_ipv4_ff && hit;
            end
            FUNC_ADD: begin
               cmd.add       = !hit && !full;
               rsp_status_in = !hit && full;
            end
            FUNC_REMOVE: begin
               cmd.remove = 1'b1;
            end
            FUNC_CLEAR: begin
               cmd.clear = 1'b1;
            end
            default: begin
               cmd = '0;
            end
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_drop_ff   <= rsp_drop_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_drop   = rsp_drop_ff;
   assign rsp_status = rsp_status_ff;

   // Every taken item gives exactly one result, in the cycle after its decode
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff == rsp_valid_ff ##0 1'b1 |=> rsp_valid_ff == $past(in_valid_ff))
      else $error("result strobe does not follow the decoded item");

   // Only a full-table add reports status, and only a lookup drops
   a_status_add: assert property (@(posedge clock) disable iff (reset)
      rsp_status_ff |-> $past(in_valid_ff) && $past(in_func_ff) == FUNC_ADD && !rsp_drop_ff)
      else $error("status raised by something other than a refused add");

   // Clear empties the table
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_func_ff == FUNC_CLEAR |=> valid_vec == '0)
      else $error("entries left valid after clear");

   // An add that was taken fills exactly one more slot
   a_add_one: assert property (@(posedge clock) disable iff (reset)
      cmd.add |=> $countones(valid_vec) == $countones($past(valid_vec)) + 1)
      else $error("add did not fill exactly one slot");

endmodule
